/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that cons holds whenever ante holds, sampled on clk, quiet in reset.
`define ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that cond holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, ante, cons)
`define ASSERT_ALWAYS(lbl, cond)
`endif
`endif

/* rtl/core/krrc_pkg.sv */
// Package with shared types, constants and the letter cost function.
`timescale 1ns / 1ps
package krrc_pkg;

    localparam int DEF_MAX_NODES = 16;
    localparam int DEF_MAX_EDGES = 120;
    localparam int NODE_W        = 4;
    localparam int CFG_W         = 5;
    localparam int LETTER_W      = 8;
    localparam int COST_W        = 6;
    localparam int WEIGHT_W      = 7;
    localparam int TOTAL_W       = 13;
    localparam int ACC_W         = 15;
    localparam int IN_DATA_W     = 32;
    localparam int OUT_DATA_W    = 16;
    localparam logic [TOTAL_W-1:0] COST_LIMIT = 13'd8191;
    localparam logic [CFG_W-1:0]   NODE_COUNT_RESET = 5'd16;
    localparam logic [LETTER_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [LETTER_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [LETTER_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [LETTER_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [COST_W-1:0]   LOWER_OFFSET = 6'd26;

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] w;
        logic [NODE_W-1:0]          a;
        logic [NODE_W-1:0]          b;
    } edge_t;

    typedef struct packed {
        logic ins;
        logic pop;
        logic clr;
    } cell_ctrl_t;

    function automatic logic [COST_W-1:0] letter_cost(input logic [LETTER_W-1:0] ch);
        logic [LETTER_W-1:0] d;
        begin
            d = '0;
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
            begin
                d = ch - CH_UPPER_A;
                letter_cost = d[COST_W-1:0];
            end
            else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
            begin
                d = ch - CH_LOWER_A;
                letter_cost = d[COST_W-1:0] + LOWER_OFFSET;
            end
            else
            begin
                letter_cost = '0;
            end
        end
    endfunction

endpackage

/* rtl/core/krrc_edge_cell.sv */
// One cell of the sorted edge chain: stable insert from the left, pop to the left.
`timescale 1ns / 1ps
module krrc_edge_cell #(
    parameter bit FIRST = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  krrc_pkg::cell_ctrl_t ctrl,
    input  krrc_pkg::edge_t     new_edge,
    input  krrc_pkg::edge_t     left_edge,
    input  logic                left_valid,
    input  krrc_pkg::edge_t     right_edge,
    input  logic                right_valid,
    output krrc_pkg::edge_t     cur_edge,
    output logic                cur_valid
);
    import krrc_pkg::*;

    edge_t edge_reg, edge_next;
    logic  valid_reg, valid_next;
    logic  keep, take_new;

    // Equal weights stay ahead of the newcomer, which keeps load order on ties.
    assign keep     = valid_reg && (edge_reg.w <= new_edge.w);
    assign take_new = FIRST ? 1'b1 : (left_valid && (left_edge.w <= new_edge.w));

    always_comb
    begin
        edge_next  = edge_reg;
        valid_next = valid_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.ins)
        begin
            if (!keep)
            begin
                if (take_new)
                begin
                    edge_next  = new_edge;
                    valid_next = 1'b1;
                end
                else
                begin
                    edge_next  = left_edge;
                    valid_next = left_valid;
                end
            end
        end
        else if (ctrl.pop)
        begin
            edge_next  = right_edge;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        edge_reg <= edge_next;
    end

    assign cur_edge  = edge_reg;
    assign cur_valid = valid_reg;

endmodule

/* rtl/core/krrc_node_cell.sv */
// One node cell: holds the component label of its node and follows merges.
`timescale 1ns / 1ps
module krrc_node_cell #(
    parameter int LBL_W = 4,
    parameter int IDX   = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clr,
    input  logic             merge,
    input  logic [LBL_W-1:0] keep_label,
    input  logic [LBL_W-1:0] drop_label,
    output logic [LBL_W-1:0] label
);
    import krrc_pkg::*;

    localparam logic [LBL_W-1:0] OWN = LBL_W'(IDX);

    logic [LBL_W-1:0] label_reg, label_next;

    always_comb
    begin
        label_next = label_reg;
        if (clr)
        begin
            label_next = OWN;
        end
        else if (merge && label_reg == drop_label)
        begin
            label_next = keep_label;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg <= OWN;
        end
        else
        begin
            label_reg <= label_next;
        end
    end

    assign label = label_reg;

endmodule

/* rtl/core/kruskal_road_rebuild_cost.sv */
// Top level of the road rebuild cost block: edge chain, node cells and control.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Road rebuild cost engine. Each input transfer carries one node pair with an
// existing-road flag and two cost letters ('A'-'Z' cost 0-25, 'a'-'z' cost 26-51,
// any other byte 0). An existing road adds its destroy cost to a base sum and
// enters with weight minus that cost; a missing road enters with its build cost.
// Pairs with an endpoint at or above node_count (capped at MAX_NODES), and pairs
// beyond MAX_EDGES, are dropped. While idle the block takes pairs back to back; each
// stored pair is inserted in weight order into a chain of MAX_EDGES edge cells,
// ties kept in load order. The transfer with tlast set starts the tree pass: the
// chain pops one edge per cycle into a row of MAX_NODES node cells holding
// component labels. s_tready stays low through the tree pass and while a previous
// result still waits in the output register. The result (base plus chosen
// weights, clamped to 0..8191) then moves into the output register and the block
// takes input again while it waits on m_tready. node_count is written through
// cfg_we / cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce.
module kruskal_road_rebuild_cost #(
    parameter int MAX_NODES = krrc_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = krrc_pkg::DEF_MAX_EDGES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [krrc_pkg::CFG_W-1:0]         cfg_wdata,   // node_count
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // node_a[3:0], node_b[7:4], road_exists[8], destroy_letter[16:9],
    // build_letter[24:17], zero fill above
    input  logic [krrc_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                               s_tlast,     // last_edge
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [krrc_pkg::OUT_DATA_W-1:0]    m_tdata      // total_cost[12:0], zero fill
);
    import krrc_pkg::*;

    localparam int CNT_W = $clog2(MAX_EDGES + 1);
    localparam int LBL_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    // Unpack the input transfer.
    logic [NODE_W-1:0]   in_a, in_b;
    logic                in_exists;
    logic [LETTER_W-1:0] in_dl, in_bl;
    assign in_a      = s_tdata[3:0];
    assign in_b      = s_tdata[7:4];
    assign in_exists = s_tdata[8];
    assign in_dl     = s_tdata[16:9];
    assign in_bl     = s_tdata[24:17];

    state_t state_reg, state_next;
    logic [CFG_W-1:0]    node_count_reg;
    logic [TOTAL_W-1:0]  base_reg, base_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [TOTAL_W-1:0]  out_reg, out_next;
    logic                out_valid_reg, out_valid_next;

    logic        accept, store;
    logic [COST_W-1:0] d_cost, b_cost;
    edge_t       new_edge;
    logic [TOTAL_W:0] base_sum_wide;
    logic [TOTAL_W-1:0] base_after;
    cell_ctrl_t  ctrl;
    logic        merge, node_clr;

    edge_t       cell_edge [MAX_EDGES];
    logic [MAX_EDGES-1:0] cell_valid;
    logic [LBL_W-1:0] label [MAX_NODES];
    logic [LBL_W-1:0] la, lb;
    edge_t       head;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign head     = cell_edge[0];

    // Drop pairs outside the node range or past a full chain.
    assign store = accept
                && ({1'b0, in_a} < node_count_reg) && (int'(in_a) < MAX_NODES)
                && ({1'b0, in_b} < node_count_reg) && (int'(in_b) < MAX_NODES)
                && (int'(count_reg) < MAX_EDGES);

    assign d_cost = letter_cost(in_dl);
    assign b_cost = letter_cost(in_bl);

    always_comb
    begin
        new_edge.a = in_a;
        new_edge.b = in_b;
        if (in_exists)
        begin
            new_edge.w = -$signed({1'b0, d_cost});
        end
        else
        begin
            new_edge.w = $signed({1'b0, b_cost});
        end
    end

    // Saturate the base sum at the cost limit.
    assign base_sum_wide = {1'b0, base_reg} + {{(TOTAL_W + 1 - COST_W){1'b0}}, d_cost};
    assign base_after = (store && in_exists)
                      ? ((base_sum_wide > {1'b0, COST_LIMIT}) ? COST_LIMIT
                                                               : base_sum_wide[TOTAL_W-1:0])
                      : base_reg;

    // Look up the component labels of the head edge's endpoints.
    always_comb
    begin
        la = '0;
        lb = '0;
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (int'(head.a) == i)
            begin
                la = label[i];
            end
            if (int'(head.b) == i)
            begin
                lb = label[i];
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ctrl           = '0;
        merge          = 1'b0;
        node_clr       = 1'b0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ctrl.ins  = store;
                    base_next = base_after;
                    if (store)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        acc_next   = $signed({{(ACC_W - TOTAL_W){1'b0}}, base_after});
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (cell_valid[0])
                begin
                    // Pop the lightest edge; join its endpoints if apart.
                    ctrl.pop   = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (la != lb)
                    begin
                        merge    = 1'b1;
                        acc_next = acc_reg + ACC_W'(head.w);
                    end
                end
                else if (!out_valid_reg || m_tready)
                begin
                    // Clamp, hand the total to the output register, clear the graph.
                    if (acc_reg < 0)
                    begin
                        out_next = '0;
                    end
                    else if (acc_reg > $signed({{(ACC_W - TOTAL_W){1'b0}}, COST_LIMIT}))
                    begin
                        out_next = COST_LIMIT;
                    end
                    else
                    begin
                        out_next = acc_reg[TOTAL_W-1:0];
                    end
                    out_valid_next = 1'b1;
                    ctrl.clr       = 1'b1;
                    node_clr       = 1'b1;
                    base_next      = '0;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            node_count_reg <= NODE_COUNT_RESET;
            base_reg       <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - TOTAL_W){1'b0}}, out_reg};

    // Sorted edge chain.
    for (genvar i = 0; i < MAX_EDGES; i++)
    begin : g_edge
        edge_t left_e, right_e;
        logic  left_v, right_v;
        if (i == 0)
        begin : g_head
            assign left_e = '0;
            assign left_v = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_edge[i-1];
            assign left_v = cell_valid[i-1];
        end
        if (i == MAX_EDGES - 1)
        begin : g_tail
            assign right_e = '0;
            assign right_v = 1'b0;
        end
        else
        begin : g_body
            assign right_e = cell_edge[i+1];
            assign right_v = cell_valid[i+1];
        end
        krrc_edge_cell #(
            .FIRST (i == 0)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .new_edge    (new_edge),
            .left_edge   (left_e),
            .left_valid  (left_v),
            .right_edge  (right_e),
            .right_valid (right_v),
            .cur_edge    (cell_edge[i]),
            .cur_valid   (cell_valid[i])
        );
    end

    // Component labels, one cell per node.
    for (genvar i = 0; i < MAX_NODES; i++)
    begin : g_node
        krrc_node_cell #(
            .LBL_W (LBL_W),
            .IDX   (i)
        ) u_node (
            .clk        (clk),
            .rst_n      (rst_n),
            .clr        (node_clr),
            .merge      (merge),
            .keep_label (la),
            .drop_label (lb),
            .label      (label[i])
        );
    end

    // The chain stays packed toward the head and matches the fill count.
    `ASSERT_ALWAYS(a_count_matches, int'(count_reg) == $countones(cell_valid))
    `ASSERT_IMPLY(a_chain_packed, !cell_valid[0], cell_valid == '0)
    // Input stalls for the whole tree pass.
    `ASSERT_IMPLY(a_run_stalls, state_reg == ST_RUN, !s_tready)

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the road rebuild cost block.
`timescale 1ns / 1ps
module testbench;
    import krrc_pkg::*;

    // Limits of the block instance under test.
    localparam int NODES = 16;
    localparam int EDGES = 120;
    // Settling time after a drain, with generous margin over the longest tree pass.
    localparam int SETTLE_CYCLES = 300;
    localparam int ITEM_TARGET = 650;
    // Past this many items both sides stop idling.
    localparam int CALM_AFTER = 560;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    kruskal_road_rebuild_cost u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // One node pair as the testbench sees it.
    typedef struct {
        logic [3:0] node_a;
        logic [3:0] node_b;
        logic       road_exists;
        logic [7:0] destroy_letter;
        logic [7:0] build_letter;
        logic       last_edge;
    } road_pair_t;

    // Directed row: a pair plus an optional hand-computed total.
    typedef struct {
        road_pair_t  pair;
        logic        typed;
        logic [12:0] total;
    } road_row_t;

    // Shadow copy of the graph held by the block.
    int         shadow_w [EDGES];
    int         shadow_a [EDGES];
    int         shadow_b [EDGES];
    int         shadow_parent [NODES];
    int         shadow_base;
    int         shadow_edges;
    int         shadow_node_count;

    logic [12:0] cost_queue [$];
    int          items_sent;
    int          mismatches;
    bit          calm;

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int letter_value(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
            return ch - "A";
        if (ch >= "a" && ch <= "z")
            return ch - "a" + 26;
        return 0;
    endfunction

    function automatic int root_of(input int x);
        int r;
        r = x;
        while (shadow_parent[r] != r)
            r = shadow_parent[r];
        return r;
    endfunction

    function automatic void clear_shadow_graph();
        for (int i = 0; i < NODES; i++)
            shadow_parent[i] = i;
        shadow_base = 0;
        shadow_edges = 0;
    endfunction

    // Load one pair into the shadow graph; on the last pair, run the
    // spanning tree and return 1 with the total in cost.
    function automatic bit predict_rebuild_cost(input road_pair_t p, output logic [12:0] cost);
        int n;
        int w;
        int ta;
        int tb;
        int j;
        int ra;
        int rb;
        int total;
        cost = '0;
        n = (shadow_node_count < NODES) ? shadow_node_count : NODES;
        if (p.node_a < n && p.node_b < n && shadow_edges < EDGES)
        begin
            if (p.road_exists)
            begin
                shadow_base += letter_value(p.destroy_letter);
                if (shadow_base > 8191)
                    shadow_base = 8191;
                w = -letter_value(p.destroy_letter);
            end
            else
            begin
                w = letter_value(p.build_letter);
            end
            shadow_w[shadow_edges] = w;
            shadow_a[shadow_edges] = p.node_a;
            shadow_b[shadow_edges] = p.node_b;
            shadow_edges++;
        end
        if (!p.last_edge)
            return 0;
        // Stable insertion sort keeps ties in load order.
        for (int i = 1; i < shadow_edges; i++)
        begin
            w = shadow_w[i];
            ta = shadow_a[i];
            tb = shadow_b[i];
            j = i;
            while (j > 0 && shadow_w[j-1] > w)
            begin
                shadow_w[j] = shadow_w[j-1];
                shadow_a[j] = shadow_a[j-1];
                shadow_b[j] = shadow_b[j-1];
                j--;
            end
            shadow_w[j] = w;
            shadow_a[j] = ta;
            shadow_b[j] = tb;
        end
        total = shadow_base;
        for (int i = 0; i < shadow_edges; i++)
        begin
            ra = root_of(shadow_a[i]);
            rb = root_of(shadow_b[i]);
            if (ra != rb)
            begin
                shadow_parent[rb] = ra;
                total += shadow_w[i];
            end
        end
        if (total < 0)
            total = 0;
        if (total > 8191)
            total = 8191;
        cost = total[12:0];
        clear_shadow_graph();
        return 1;
    endfunction

    // Drive one pair at the falling edge and hold it until the transfer.
    // On the last pair, the predictor result is queued unless a typed total is given.
    task automatic send_pair(input road_pair_t p, input bit typed, input logic [12:0] total);
        int gap;
        logic [12:0] cost;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 15);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {7'b0, p.build_letter, p.destroy_letter, p.road_exists,
                    p.node_b, p.node_a};
        s_tlast  = p.last_edge;
        do
            @(posedge clk);
        while (!s_tready);
        if (predict_rebuild_cost(p, cost))
            cost_queue = {cost_queue, (typed ? total : cost)};
        items_sent++;
    endtask

    // Drop valid and hold off until every queued total has come out,
    // then let any tree pass in flight finish.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tlast  = 1'b0;
        while (cost_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_node_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        shadow_node_count = value;
    endtask

    function automatic logic [7:0] random_letter();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            1: return 8'("a" + $urandom_range(0, 25));
            default: return 8'("A" + $urandom_range(0, 25));
        endcase
    endfunction

    // One random graph of count pairs; endpoints mostly in range.
    task automatic send_graph(input int count);
        road_pair_t p;
        int n;
        n = (shadow_node_count < NODES) ? shadow_node_count : NODES;
        if (n < 1)
            n = 1;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                p.node_a = 4'($urandom_range(0, 15));
                p.node_b = 4'($urandom_range(0, 15));
            end
            else
            begin
                p.node_a = 4'($urandom_range(0, n - 1));
                p.node_b = 4'($urandom_range(0, n - 1));
            end
            p.road_exists    = 1'($urandom_range(0, 1));
            p.destroy_letter = random_letter();
            p.build_letter   = random_letter();
            p.last_edge      = (i == count - 1);
            send_pair(p, 1'b0, '0);
        end
    endtask

    // Receiver side: stall in random bursts, none once calm.
    int stall_left;
    always @(negedge clk)
    begin
        if (calm)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(1, 15) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each result transfer with the oldest queued total.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cost_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result total_cost=%0d", m_tdata[12:0]);
            end
            else
            begin
                if (m_tdata[12:0] !== cost_queue[0] || m_tdata[15:13] !== 3'b0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("total_cost mismatch: expected %0d, got %0d",
                                 cost_queue[0], m_tdata);
                end
                void'(cost_queue.pop_front());
            end
        end
    end

    // Watchdog well past the slowest legal run.
    initial
    begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    road_row_t directed [] = '{
        // Cheapest and dearest build letters.
        '{'{4'd0, 4'd1, 1'b0, 8'h00, "A", 1'b1}, 1'b1, 13'd0},
        '{'{4'd0, 4'd1, 1'b0, 8'h00, "z", 1'b1}, 1'b1, 13'd51},
        '{'{4'd0, 4'd1, 1'b0, 8'h00, "Z", 1'b1}, 1'b1, 13'd25},
        '{'{4'd0, 4'd1, 1'b0, 8'h00, "a", 1'b1}, 1'b1, 13'd26},
        // Bytes just outside the letter ranges cost nothing.
        '{'{4'd0, 4'd1, 1'b0, 8'h00, 8'h40, 1'b1}, 1'b1, 13'd0},
        '{'{4'd0, 4'd1, 1'b0, 8'h00, 8'h5B, 1'b1}, 1'b1, 13'd0},
        '{'{4'd0, 4'd1, 1'b0, 8'h00, 8'h60, 1'b1}, 1'b1, 13'd0},
        '{'{4'd0, 4'd1, 1'b0, 8'h00, 8'h7B, 1'b1}, 1'b1, 13'd0},
        '{'{4'd0, 4'd1, 1'b0, 8'hFF, 8'hFF, 1'b1}, 1'b1, 13'd0},
        // Existing road: destroy cost in base, cancelled by negative weight.
        '{'{4'd0, 4'd1, 1'b1, "z", 8'hFF, 1'b1}, 1'b1, 13'd0},
        // Self pair on the top node: base only, never chosen.
        '{'{4'd15, 4'd15, 1'b1, "Z", "z", 1'b1}, 1'b1, 13'd25},
        // Triangle: two cheapest edges win.
        '{'{4'd0, 4'd1, 1'b0, 8'h00, "C", 1'b0}, 1'b0, 13'd0},
        '{'{4'd1, 4'd2, 1'b0, 8'h00, "B", 1'b0}, 1'b0, 13'd0},
        '{'{4'd2, 4'd0, 1'b0, 8'h00, "A", 1'b1}, 1'b1, 13'd1},
        // Mixed graph with ties, checked by the predictor.
        '{'{4'd15, 4'd3, 1'b1, "c", "B", 1'b0}, 1'b0, 13'd0},
        '{'{4'd3, 4'd9, 1'b0, "q", "D", 1'b0}, 1'b0, 13'd0},
        '{'{4'd9, 4'd15, 1'b0, 8'h80, "D", 1'b0}, 1'b0, 13'd0},
        '{'{4'd3, 4'd15, 1'b1, "D", 8'h7F, 1'b0}, 1'b0, 13'd0},
        '{'{4'd9, 4'd9, 1'b1, "m", "x", 1'b1}, 1'b0, 13'd0}
    };

    int  graph_size;
    logic [CFG_W-1:0] phase_counts [] = '{5'd2, 5'd31, 5'd0, 5'd1, 5'd3, 5'd16, 5'd17, 5'd8};
    int  phase;

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        stall_left = 0;
        calm       = 1'b0;
        items_sent = 0;
        mismatches = 0;
        shadow_node_count = 16;
        clear_shadow_graph();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part at the reset node count.
        foreach (directed[i])
            send_pair(directed[i].pair, directed[i].typed, directed[i].total);
        drain_results();

        // Random part: walk node count settings, several graphs each.
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (phase < phase_counts.size())
                write_node_count(phase_counts[phase]);
            else
                write_node_count(CFG_W'($urandom_range(0, 31)));
            phase++;
            for (int g = 0; g < 6 && items_sent < ITEM_TARGET; g++)
            begin
                // One overfull graph exercises the store limit.
                if (phase == 6 && g == 0)
                    graph_size = EDGES + 6;
                else
                    graph_size = $urandom_range(1, 20);
                if (items_sent > CALM_AFTER)
                    calm = 1'b1;
                send_graph(graph_size);
                if ($urandom_range(0, 3) == 0)
                    drain_results();
            end
            drain_results();
        end

        if (mismatches == 0 && cost_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* kruskal_road_rebuild_cost.f */
+incdir+rtl/core
rtl/core/krrc_pkg.sv
rtl/core/krrc_edge_cell.sv
rtl/core/krrc_node_cell.sv
rtl/core/kruskal_road_rebuild_cost.sv
dv/testbench.sv
